// File: sv/tpr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tpr_pkg
// Shared types, codes and helper functions of the tile-map pixel renderer.
// ----------------------------------------------------------------------------
package tpr_pkg;

   // command codes on req_cmd
   localparam logic [1:0] CMD_WR_VRAM = 2'd0;
   localparam logic [1:0] CMD_WR_CRAM = 2'd1;
   localparam logic [1:0] CMD_RENDER  = 2'd2;

   // configuration register indexes
   localparam logic REG_COLOR_MODE = 1'b0;
   localparam logic REG_BG_SHADES  = 1'b1;

   localparam int VRAM_DEPTH = 16384;
   localparam int CRAM_DEPTH = 64;

   localparam logic [13:0] MAP_BASE    = 14'h1800;
   localparam logic [13:0] BANK_OFFSET = 14'h2000;
   localparam logic [7:0]  WINDOW_SPAN = 8'd159;
   localparam logic [7:0]  NO_LINE     = 8'd144;
   localparam logic [7:0]  LINE_TOP    = 8'd0;
   localparam logic [7:0]  LINE_BOTTOM = 8'd143;

   localparam logic [23:0] RGB_GREEN = 24'h00FF00;
   localparam logic [23:0] RGB_BLUE  = 24'hFF0000;

   typedef enum logic [1:0] {
      KIND_VRAM,
      KIND_CRAM,
      KIND_RENDER
   } kind_type;

   typedef enum logic [1:0] {
      MARK_NONE,
      MARK_GREEN,
      MARK_BLUE
   } mark_type;

   typedef struct packed {
      logic       color_mode;
      logic [7:0] bg_shades;
   } cfg_type;

   typedef struct packed {
      kind_type    kind;
      logic [13:0] addr;
      logic [7:0]  data;
      logic        map_sel;
      logic [7:0]  row;
      logic [4:0]  col;
      logic [7:0]  scroll;
      logic [7:0]  line;
      logic        uns;
   } queue_entry_type;

   typedef struct packed {
      logic [7:0] p0;
      logic [7:0] p1;
      logic [2:0] palette;
      logic       xflip;
      logic [4:0] col;
      logic [7:0] scroll;
      logic [7:0] line;
   } pixel_job_type;

   typedef struct packed {
      logic       we;
      logic [5:0] addr;
      logic [7:0] data;
   } cram_write_type;

   function automatic logic [7:0] expand5(input logic [4:0] v);
      return {v, v[4:2]};
   endfunction

   // 0x555555 * (3 - shade)
   function automatic logic [23:0] gray_rgb(input logic [1:0] shade);
      logic [23:0] c;
      unique case (shade)
         2'd0: c = 24'hFFFFFF;
         2'd1: c = 24'hAAAAAA;
         2'd2: c = 24'h555555;
         2'd3: c = 24'h000000;
         default: c = 24'h000000;
      endcase
      return c;
   endfunction

endpackage
`default_nettype wire

// File: sv/tpr_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tpr_ram
// Single-port RAM, one write or read per cycle, registered read data.
// ----------------------------------------------------------------------------
module tpr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16384
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wdata,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata <= mem[addr];
   end

endmodule
`default_nettype wire

// File: sv/tpr_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tpr_front
// Accepts command words, drops the ones with no effect and queues the rest
// in order for the back end.
// ----------------------------------------------------------------------------
module tpr_front #(
   parameter int QUEUE_DEPTH = 4
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     start,
   output logic                          busy,
   input  wire logic [1:0]               req_cmd,
   input  wire logic [13:0]              req_mem_address,
   input  wire logic [7:0]               req_write_data,
   input  wire logic                     req_map_select,
   input  wire logic [7:0]               req_map_row,
   input  wire logic [4:0]               req_tile_column,
   input  wire logic [7:0]               req_row_scroll_x,
   input  wire logic [7:0]               req_lcd_line,
   input  wire logic                     req_unsigned_tiles,
   input  wire logic                     pop,
   output logic                          head_valid,
   output tpr_pkg::queue_entry_type      head
);
   import tpr_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   queue_entry_type  queue_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             keep;
   logic             push;
   queue_entry_type  entry;

   // color RAM writes outside 0..63 and unknown commands leave no trace
   always_comb begin
      keep       = 1'b0;
      entry.kind = KIND_RENDER;
      unique case (req_cmd)
         CMD_WR_VRAM: begin
            keep       = 1'b1;
            entry.kind = KIND_VRAM;
         end
         CMD_WR_CRAM: begin
            keep       = (req_mem_address[13:6] == 8'd0);
            entry.kind = KIND_CRAM;
         end
         CMD_RENDER: begin
            keep       = 1'b1;
            entry.kind = KIND_RENDER;
         end
         default: begin
            keep       = 1'b0;
         end
      endcase
      entry.addr    = req_mem_address;
      entry.data    = req_write_data;
      entry.map_sel = req_map_select;
      entry.row     = req_map_row;
      entry.col     = req_tile_column;
      entry.scroll  = req_row_scroll_x;
      entry.line    = req_lcd_line;
      entry.uns     = req_unsigned_tiles;
   end

   assign busy       = (cnt_ff == CNT_W'(QUEUE_DEPTH));
   assign push       = start && !busy && keep;
   assign head_valid = (cnt_ff != '0);
   assign head       = queue_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      unique case ({push, pop})
         2'b10: cnt_in = cnt_ff + 1'b1;
         2'b01: cnt_in = cnt_ff - 1'b1;
         default: cnt_in = cnt_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= entry;
      end
   end

endmodule
`default_nettype wire

// File: sv/tpr_fetch.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tpr_fetch
// Back end, memory side: owns video memory, carries out writes and fetches
// map entry, attribute (color mode only) and both bit planes of a tile row.
// ----------------------------------------------------------------------------
module tpr_fetch (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire tpr_pkg::cfg_type         cfg,
   input  wire logic                     head_valid,
   input  wire tpr_pkg::queue_entry_type head,
   output logic                          pop,
   input  wire logic                     cram_free,
   output tpr_pkg::cram_write_type       cram_wr,
   output logic                          job_valid,
   input  wire logic                     job_ready,
   output tpr_pkg::pixel_job_type        job
);
   import tpr_pkg::*;

   typedef enum logic [5:0] {
      F_IDLE   = 6'b000001,
      F_TILE   = 6'b000010,
      F_ATTR   = 6'b000100,
      F_PLANE0 = 6'b001000,
      F_PLANE1 = 6'b010000,
      F_HAND   = 6'b100000
   } fetch_state_type;

   fetch_state_type state_ff, state_in;

   logic [13:0] map_addr_ff, map_addr_in;
   logic [13:0] pat_ff, pat_in;
   logic [7:0]  tile_ff, tile_in;
   logic [7:0]  attr_ff, attr_in;
   logic [7:0]  p0_ff, p0_in;
   logic [7:0]  p1_ff, p1_in;
   logic [2:0]  row_lo_ff, row_lo_in;
   logic        uns_ff, uns_in;
   logic [4:0]  col_ff, col_in;
   logic [7:0]  scroll_ff, scroll_in;
   logic [7:0]  line_ff, line_in;

   logic        vram_we;
   logic [13:0] vram_addr;
   logic [7:0]  vram_wdata;
   logic [7:0]  vram_rdata;

   // first plane byte of the tile row; the second one is at pattern | 1
   function automatic logic [13:0] pattern_addr(
      input logic [7:0] tile,
      input logic [7:0] attr,
      input logic [2:0] row_lo,
      input logic       uns,
      input logic       color_mode
   );
      logic [2:0] yb;
      logic       bank;
      yb   = (color_mode && attr[6]) ? ~row_lo : row_lo;
      bank = color_mode && attr[3];
      return {bank, ~uns & ~tile[7], tile, yb, 1'b0};
   endfunction

   tpr_ram #(
      .WIDTH (8),
      .DEPTH (VRAM_DEPTH)
   ) u_vram (
      .clock (clock),
      .we    (vram_we),
      .addr  (vram_addr),
      .wdata (vram_wdata),
      .rdata (vram_rdata)
   );

   always_comb begin
      state_in    = state_ff;
      map_addr_in = map_addr_ff;
      pat_in      = pat_ff;
      tile_in     = tile_ff;
      attr_in     = attr_ff;
      p0_in       = p0_ff;
      p1_in       = p1_ff;
      row_lo_in   = row_lo_ff;
      uns_in      = uns_ff;
      col_in      = col_ff;
      scroll_in   = scroll_ff;
      line_in     = line_ff;
      pop         = 1'b0;
      vram_we     = 1'b0;
      vram_addr   = head.addr;
      vram_wdata  = head.data;
      cram_wr     = '0;
      job_valid   = 1'b0;

      unique case (state_ff)
         F_IDLE: begin
            if (head_valid) begin
               unique case (head.kind)
                  KIND_VRAM: begin
                     vram_we = 1'b1;
                     pop     = 1'b1;
                  end
                  KIND_CRAM: begin
                     // hold until the pixel unit is done reading palettes
                     if (cram_free) begin
                        cram_wr.we   = 1'b1;
                        cram_wr.addr = head.addr[5:0];
                        cram_wr.data = head.data;
                        pop          = 1'b1;
                     end
                  end
                  KIND_RENDER: begin
                     map_addr_in = MAP_BASE |
                                   {3'b000, head.map_sel, head.row[7:3], head.col};
                     vram_addr   = map_addr_in;
                     row_lo_in   = head.row[2:0];
                     uns_in      = head.uns;
                     col_in      = head.col;
                     scroll_in   = head.scroll;
                     line_in     = head.line;
                     pop         = 1'b1;
                     state_in    = F_TILE;
                  end
                  default: begin
                     pop = 1'b1;
                  end
               endcase
            end
         end
         F_TILE: begin
            tile_in = vram_rdata;
            if (cfg.color_mode) begin
               vram_addr = map_addr_ff | BANK_OFFSET;
               state_in  = F_ATTR;
            end else begin
               attr_in   = '0;
               pat_in    = pattern_addr(vram_rdata, 8'd0, row_lo_ff, uns_ff, 1'b0);
               vram_addr = pat_in;
               state_in  = F_PLANE0;
            end
         end
         F_ATTR: begin
            attr_in   = vram_rdata;
            pat_in    = pattern_addr(tile_ff, vram_rdata, row_lo_ff, uns_ff, 1'b1);
            vram_addr = pat_in;
            state_in  = F_PLANE0;
         end
         F_PLANE0: begin
            p0_in     = vram_rdata;
            vram_addr = pat_ff | 14'd1;
            state_in  = F_PLANE1;
         end
         F_PLANE1: begin
            p1_in    = vram_rdata;
            state_in = F_HAND;
         end
         F_HAND: begin
            job_valid = 1'b1;
            if (job_ready) begin
               state_in = F_IDLE;
            end
         end
         default: begin
            state_in = F_IDLE;
         end
      endcase
   end

   always_comb begin
      job.p0      = p0_ff;
      job.p1      = p1_ff;
      job.palette = attr_ff[2:0];
      job.xflip   = attr_ff[5];
      job.col     = col_ff;
      job.scroll  = scroll_ff;
      job.line    = line_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      map_addr_ff <= map_addr_in;
      pat_ff      <= pat_in;
      tile_ff     <= tile_in;
      attr_ff     <= attr_in;
      p0_ff       <= p0_in;
      p1_ff       <= p1_in;
      row_lo_ff   <= row_lo_in;
      uns_ff      <= uns_in;
      col_ff      <= col_in;
      scroll_ff   <= scroll_in;
      line_ff     <= line_in;
   end

endmodule
`default_nettype wire

// File: sv/tpr_pixel.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tpr_pixel
// Back end, pixel side: owns color RAM, walks the eight pixels of a tile
// row, looks up colors and applies scroll-window markers.
// ----------------------------------------------------------------------------
module tpr_pixel (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire tpr_pkg::cfg_type         cfg,
   input  wire logic                     job_valid,
   output logic                          job_ready,
   input  wire tpr_pkg::pixel_job_type   job,
   input  wire tpr_pkg::cram_write_type  cram_wr,
   output logic                          cram_free,
   output logic                          rsp_valid,
   output logic [23:0]                   rsp_pixel_rgb,
   output logic [7:0]                    rsp_pixel_x,
   output logic                          rsp_last_pixel
);
   import tpr_pkg::*;

   localparam int CRAM_WORDS = CRAM_DEPTH / 2;

   // stage A: pixel walk
   logic          active_ff, active_in;
   logic [2:0]    idx_ff, idx_in;
   pixel_job_type job_ff;
   logic [7:0]    right_ff;
   logic          take;
   logic [2:0]    bitsel;
   logic [1:0]    code;
   logic [7:0]    x;
   mark_type      mark;
   logic          has_line;
   logic          in_window;

   // stage B: color lookup
   logic       b_valid_ff;
   logic [1:0] b_code_ff;
   logic [7:0] b_x_ff;
   logic       b_last_ff;
   mark_type   b_mark_ff;
   logic [15:0] word;
   logic [23:0] color;

   // even and odd bytes of each palette word live in separate RAMs
   logic [$clog2(CRAM_WORDS)-1:0] cram_addr;
   logic       even_we, odd_we;
   logic [7:0] even_rdata, odd_rdata;

   logic       rsp_valid_ff;
   logic [23:0] rsp_rgb_ff;
   logic [7:0] rsp_x_ff;
   logic       rsp_last_ff;

   assign job_ready = !active_ff || (idx_ff == 3'd7);
   assign take      = job_valid && job_ready;
   assign cram_free = !active_ff;

   always_comb begin
      active_in = active_ff;
      idx_in    = idx_ff;
      if (take) begin
         active_in = 1'b1;
         idx_in    = '0;
      end else if (active_ff) begin
         idx_in = idx_ff + 1'b1;
         if (idx_ff == 3'd7) begin
            active_in = 1'b0;
         end
      end
   end

   always_comb begin
      bitsel   = job_ff.xflip ? idx_ff : ~idx_ff;
      code     = {job_ff.p1[bitsel], job_ff.p0[bitsel]};
      x        = {job_ff.col, idx_ff};
      has_line = (job_ff.line < NO_LINE);
      if (right_ff < job_ff.scroll) begin
         in_window = (x <= right_ff) || (x >= job_ff.scroll);
      end else begin
         in_window = (x <= right_ff) && (x >= job_ff.scroll);
      end
      mark = MARK_NONE;
      if (has_line && (x == job_ff.scroll)) begin
         mark = MARK_GREEN;
      end
      if (has_line && (x == right_ff)) begin
         mark = MARK_BLUE;
      end
      // top and bottom lines fill the whole window
      if (in_window && (job_ff.line == LINE_TOP)) begin
         mark = MARK_GREEN;
      end
      if (in_window && (job_ff.line == LINE_BOTTOM)) begin
         mark = MARK_BLUE;
      end
   end

   assign cram_addr = cram_wr.we ? cram_wr.addr[5:1] : {job_ff.palette, code};
   assign even_we   = cram_wr.we && !cram_wr.addr[0];
   assign odd_we    = cram_wr.we && cram_wr.addr[0];

   tpr_ram #(
      .WIDTH (8),
      .DEPTH (CRAM_WORDS)
   ) u_cram_even (
      .clock (clock),
      .we    (even_we),
      .addr  (cram_addr),
      .wdata (cram_wr.data),
      .rdata (even_rdata)
   );

   tpr_ram #(
      .WIDTH (8),
      .DEPTH (CRAM_WORDS)
   ) u_cram_odd (
      .clock (clock),
      .we    (odd_we),
      .addr  (cram_addr),
      .wdata (cram_wr.data),
      .rdata (odd_rdata)
   );

   always_comb begin
      word = {odd_rdata, even_rdata};
      if (cfg.color_mode) begin
         color = {expand5(word[14:10]), expand5(word[9:5]), expand5(word[4:0])};
      end else begin
         color = gray_rgb(cfg.bg_shades[{b_code_ff, 1'b0} +: 2]);
      end
      unique case (b_mark_ff)
         MARK_GREEN: color = RGB_GREEN;
         MARK_BLUE:  color = RGB_BLUE;
         default:    color = color;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         idx_ff       <= '0;
         b_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         idx_ff       <= idx_in;
         b_valid_ff   <= active_ff;
         rsp_valid_ff <= b_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         job_ff   <= job;
         right_ff <= job.scroll + WINDOW_SPAN;
      end
      b_code_ff   <= code;
      b_x_ff      <= x;
      b_last_ff   <= (idx_ff == 3'd7);
      b_mark_ff   <= mark;
      rsp_rgb_ff  <= color;
      rsp_x_ff    <= b_x_ff;
      rsp_last_ff <= b_last_ff;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_pixel_rgb  = rsp_rgb_ff;
   assign rsp_pixel_x    = rsp_x_ff;
   assign rsp_last_pixel = rsp_last_ff;

endmodule
`default_nettype wire

// File: sv/tilemap_pixel_renderer_top.sv
`timescale 1ns / 1ps
`default_nettype none
// With the back end idle, a render word passes the queue, the fetch states
// (map entry, attribute in color mode only, plane bytes, hand-off), pixel walk,
// color lookup and response register; its eight pixels follow back to back.
// The next word's fetch overlaps the pixel walk, so the single pixel result
// port sets throughput; a color RAM write waits for pixels.
// Reset clears control state only; video and color memory keep contents.
// ----------------------------------------------------------------------------
// tilemap_pixel_renderer_top
// Tile-map background renderer: command queue, fetch unit, pixel unit.
// ----------------------------------------------------------------------------
module tilemap_pixel_renderer_top #(
   parameter int QUEUE_DEPTH = 4
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [1:0]  req_cmd,
   input  wire logic [13:0] req_mem_address,
   input  wire logic [7:0]  req_write_data,
   input  wire logic        req_map_select,
   input  wire logic [7:0]  req_map_row,
   input  wire logic [4:0]  req_tile_column,
   input  wire logic [7:0]  req_row_scroll_x,
   input  wire logic [7:0]  req_lcd_line,
   input  wire logic        req_unsigned_tiles,
   output logic             rsp_valid,
   output logic [23:0]      rsp_pixel_rgb,
   output logic [7:0]       rsp_pixel_x,
   output logic             rsp_last_pixel,
   input  wire logic        csr_write_enable,
   input  wire logic        csr_index,
   input  wire logic [7:0]  csr_write_data
);
   import tpr_pkg::*;

   cfg_type         cfg_ff, cfg_in;
   logic            head_valid;
   queue_entry_type head;
   logic            pop;
   logic            cram_free;
   cram_write_type  cram_wr;
   logic            job_valid;
   logic            job_ready;
   pixel_job_type   job;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            REG_COLOR_MODE: cfg_in.color_mode = csr_write_data[0];
            REG_BG_SHADES:  cfg_in.bg_shades  = csr_write_data;
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   tpr_front #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_front (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_cmd            (req_cmd),
      .req_mem_address    (req_mem_address),
      .req_write_data     (req_write_data),
      .req_map_select     (req_map_select),
      .req_map_row        (req_map_row),
      .req_tile_column    (req_tile_column),
      .req_row_scroll_x   (req_row_scroll_x),
      .req_lcd_line       (req_lcd_line),
      .req_unsigned_tiles (req_unsigned_tiles),
      .pop                (pop),
      .head_valid         (head_valid),
      .head               (head)
   );

   tpr_fetch u_fetch (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .head_valid (head_valid),
      .head       (head),
      .pop        (pop),
      .cram_free  (cram_free),
      .cram_wr    (cram_wr),
      .job_valid  (job_valid),
      .job_ready  (job_ready),
      .job        (job)
   );

   tpr_pixel u_pixel (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg_ff),
      .job_valid      (job_valid),
      .job_ready      (job_ready),
      .job            (job),
      .cram_wr        (cram_wr),
      .cram_free      (cram_free),
      .rsp_valid      (rsp_valid),
      .rsp_pixel_rgb  (rsp_pixel_rgb),
      .rsp_pixel_x    (rsp_pixel_x),
      .rsp_last_pixel (rsp_last_pixel)
   );

endmodule
`default_nettype wire
